// ----- design/i2cm_pkg.sv -----
// i2cm_pkg: shared types and codes for the I2C master bit engine.
// No dependencies; imported by i2cm_engine, i2c_master_bit_engine_top and tb.
`default_nettype none

package i2cm_pkg;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd360;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_BEGIN = 2'd1;
	localparam logic [1:0] ACT_BYTE  = 2'd2;

	localparam logic [1:0] KIND_WR    = 2'd0;
	localparam logic [1:0] KIND_RD    = 2'd1;
	localparam logic [1:0] KIND_REGWR = 2'd2;
	localparam logic [1:0] KIND_REGRD = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NACK  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [25:0] {
		P_IDLE    = 26'b1 << 0,
		P_ST_SDAH = 26'b1 << 1,
		P_ST_SCLH = 26'b1 << 2,
		P_ST_SDAL = 26'b1 << 3,
		P_ST_SCLL = 26'b1 << 4,
		P_TX_BIT  = 26'b1 << 5,
		P_TX_SCLH = 26'b1 << 6,
		P_TX_SCLL = 26'b1 << 7,
		P_TX_REL  = 26'b1 << 8,
		P_AK_SDAH = 26'b1 << 9,
		P_AK_SCLH = 26'b1 << 10,
		P_AK_SCLL = 26'b1 << 11,
		P_RX_REL  = 26'b1 << 12,
		P_RX_SCLH = 26'b1 << 13,
		P_RX_SCLL = 26'b1 << 14,
		P_MA_SDAL = 26'b1 << 15,
		P_MA_SCLH = 26'b1 << 16,
		P_MA_SCLL = 26'b1 << 17,
		P_MA_SDAH = 26'b1 << 18,
		P_MN_SDAH = 26'b1 << 19,
		P_MN_SCLH = 26'b1 << 20,
		P_MN_SCLL = 26'b1 << 21,
		P_SP_SDAL = 26'b1 << 22,
		P_SP_SCLH = 26'b1 << 23,
		P_SP_SDAH = 26'b1 << 24,
		P_WAIT    = 26'b1 << 25
	} phase_t;

	typedef enum logic [1:0] {
		STG_ADDR  = 2'd0,
		STG_REG   = 2'd1,
		STG_RADDR = 2'd2,
		STG_DATA  = 2'd3
	} stage_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  kind;
		logic [6:0]  tgt_addr;
		logic [7:0]  reg_addr;
		logic [15:0] length;
		logic [7:0]  write_byte;
		logic        sda_level;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy_res;
		logic       want_byte;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

// ----- design/i2cm_engine.sv -----
// i2cm_engine: bus phase sequencer state and its next-state/result logic.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire item_t       item,
	input  wire logic [15:0] half_period,
	output result_t          res
);

	phase_t      phase_q, n_phase;
	stage_t      stage_q, n_stage;
	logic [15:0] timer_q, n_timer;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] left_q, n_left;
	logic [7:0]  held_q, n_held;
	logic        full_q, n_full;
	logic [1:0]  kind_q, n_kind;
	logic [6:0]  addr_q, n_addr;
	logic [7:0]  reg_q, n_reg;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        ack_q, n_ack;
	logic        nack_q, n_nack;

	logic        ent, do_load, wants, rw;
	logic [15:0] hp_eff;

	assign hp_eff = (half_period == 16'd0) ? 16'd1 : half_period;
	assign wants  = (phase_q != P_IDLE) && (kind_q == KIND_WR || kind_q == KIND_REGWR)
		&& (left_q != 16'd0) && !full_q;
	assign rw     = (stage_q == STG_RADDR) || (stage_q == STG_ADDR && kind_q == KIND_RD);

	always_comb begin
		n_phase = phase_q;
		n_stage = stage_q;
		n_timer = timer_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_held  = held_q;
		n_full  = full_q;
		n_kind  = kind_q;
		n_addr  = addr_q;
		n_reg   = reg_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		n_nack  = nack_q;
		ent     = 1'b0;
		do_load = 1'b0;
		res     = '0;

		unique case (item.action)
			ACT_TICK: begin
				if (phase_q == P_IDLE) begin
				end else if (phase_q == P_WAIT) begin
					do_load = full_q;
				end else if (timer_q > 16'd1) begin
					n_timer = timer_q - 16'd1;
				end else begin
					ent = 1'b1;
					unique case (phase_q)
						P_ST_SDAH: n_phase = P_ST_SCLH;
						P_ST_SCLH: n_phase = P_ST_SDAL;
						P_ST_SDAL: n_phase = P_ST_SCLL;
						P_ST_SCLL: begin
							n_shift = {addr_q, rw};
							n_bit   = 4'd0;
							n_phase = P_TX_BIT;
						end
						P_TX_BIT:  n_phase = P_TX_SCLH;
						P_TX_SCLH: n_phase = P_TX_SCLL;
						P_TX_SCLL: begin
							n_shift = {shift_q[6:0], 1'b0};
							n_bit   = bit_q + 4'd1;
							n_phase = n_bit[3] ? P_TX_REL : P_TX_BIT;
						end
						P_TX_REL:  n_phase = P_AK_SDAH;
						P_AK_SDAH: n_phase = P_AK_SCLH;
						P_AK_SCLH: begin
							n_ack   = item.sda_level;
							n_phase = P_AK_SCLL;
						end
						P_AK_SCLL: begin
							if (ack_q) begin
								n_nack  = 1'b1;
								n_phase = P_SP_SDAL;
							end else begin
								unique case (stage_q)
									STG_ADDR: begin
										if (kind_q == KIND_RD) begin
											n_bit   = 4'd0;
											n_shift = 8'd0;
											n_phase = P_RX_REL;
										end else if (kind_q == KIND_WR) begin
											n_stage = STG_DATA;
											ent     = 1'b0;
											do_load = 1'b1;
										end else begin
											n_stage = STG_REG;
											n_shift = reg_q;
											n_bit   = 4'd0;
											n_phase = P_TX_BIT;
										end
									end
									STG_REG: begin
										if (kind_q == KIND_REGWR) begin
											n_stage = STG_DATA;
											ent     = 1'b0;
											do_load = 1'b1;
										end else begin
											n_stage = STG_RADDR;
											n_phase = P_ST_SDAH;
										end
									end
									STG_RADDR: begin
										n_bit   = 4'd0;
										n_shift = 8'd0;
										n_phase = P_RX_REL;
									end
									default: begin
										if (left_q != 16'd0) begin
											ent     = 1'b0;
											do_load = 1'b1;
										end else begin
											n_nack  = 1'b0;
											n_phase = P_SP_SDAL;
										end
									end
								endcase
							end
						end
						P_RX_REL:  n_phase = P_RX_SCLH;
						P_RX_SCLH: begin
							n_shift = {shift_q[6:0], item.sda_level};
							n_bit   = bit_q + 4'd1;
							if (n_bit[3]) begin
								if (left_q != 16'd0)
									n_left = left_q - 16'd1;
								res.read_valid = 1'b1;
								res.read_data  = n_shift;
								res.read_last  = (n_left == 16'd0);
							end
							n_phase = P_RX_SCLL;
						end
						P_RX_SCLL: begin
							if (!bit_q[3])
								n_phase = P_RX_SCLH;
							else
								n_phase = (left_q != 16'd0) ? P_MA_SDAL : P_MN_SDAH;
						end
						P_MA_SDAL: n_phase = P_MA_SCLH;
						P_MA_SCLH: n_phase = P_MA_SCLL;
						P_MA_SCLL: n_phase = P_MA_SDAH;
						P_MA_SDAH: begin
							n_bit   = 4'd0;
							n_shift = 8'd0;
							n_phase = P_RX_REL;
						end
						P_MN_SDAH: n_phase = P_MN_SCLH;
						P_MN_SCLH: n_phase = P_MN_SCLL;
						P_MN_SCLL: begin
							n_nack  = 1'b0;
							n_phase = P_SP_SDAL;
						end
						P_SP_SDAL: n_phase = P_SP_SCLH;
						P_SP_SCLH: n_phase = P_SP_SDAH;
						default: begin
							ent          = 1'b0;
							n_phase      = P_IDLE;
							n_timer      = 16'd0;
							n_full       = 1'b0;
							n_left       = 16'd0;
							res.done_res = 1'b1;
							res.status   = nack_q ? ST_NACK : ST_OK;
						end
					endcase
				end
			end
			ACT_BEGIN: begin
				if (phase_q == P_IDLE) begin
					if (item.length == 16'd0) begin
						res.done_res = 1'b1;
						res.status   = ST_EMPTY;
					end else begin
						n_kind  = item.kind;
						n_addr  = item.tgt_addr;
						n_reg   = item.reg_addr;
						n_left  = item.length;
						n_full  = 1'b0;
						n_stage = STG_ADDR;
						n_ack   = 1'b0;
						n_nack  = 1'b0;
						n_bit   = 4'd0;
						n_shift = 8'd0;
						n_phase = P_ST_SDAH;
						ent     = 1'b1;
					end
				end
			end
			ACT_BYTE: begin
				if (wants) begin
					n_held = item.write_byte;
					n_full = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// holding register to shifter, or park with SCL low
		if (do_load) begin
			if (full_q) begin
				n_full = 1'b0;
				if (left_q != 16'd0)
					n_left = left_q - 16'd1;
				n_shift = held_q;
				n_bit   = 4'd0;
				n_phase = P_TX_BIT;
				ent     = 1'b1;
			end else begin
				n_phase = P_WAIT;
			end
		end

		if (ent) begin
			n_timer = hp_eff;
			unique case (n_phase)
				P_ST_SDAH, P_TX_REL, P_AK_SDAH, P_RX_REL,
				P_MA_SDAH, P_MN_SDAH, P_SP_SDAH: n_sda = 1'b1;
				P_ST_SDAL, P_MA_SDAL, P_SP_SDAL: n_sda = 1'b0;
				P_TX_BIT: n_sda = n_shift[7];
				P_ST_SCLH, P_TX_SCLH, P_AK_SCLH, P_RX_SCLH,
				P_MA_SCLH, P_MN_SCLH, P_SP_SCLH: n_scl = 1'b1;
				default: n_scl = 1'b0;
			endcase
		end

		res.scl       = n_scl;
		res.sda       = n_sda;
		res.busy_res  = (n_phase != P_IDLE);
		res.want_byte = (n_phase != P_IDLE) && (n_kind == KIND_WR || n_kind == KIND_REGWR)
			&& (n_left != 16'd0) && !n_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			stage_q <= STG_ADDR;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			held_q  <= '0;
			full_q  <= 1'b0;
			kind_q  <= '0;
			addr_q  <= '0;
			reg_q   <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			nack_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			stage_q <= n_stage;
			timer_q <= n_timer;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			left_q  <= n_left;
			held_q  <= n_held;
			full_q  <= n_full;
			kind_q  <= n_kind;
			addr_q  <= n_addr;
			reg_q   <= n_reg;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			ack_q   <= n_ack;
			nack_q  <= n_nack;
		end
	end

endmodule

`default_nettype wire

// ----- design/i2c_master_bit_engine_top.sv -----
// i2c_master_bit_engine_top: input register, phase engine, output register.
// Depends on i2cm_pkg and i2cm_engine.
//
//  channel  | dir | accepted when                   | carries
//  s_axis   | in  | s_axis_tvalid & s_axis_tready   | one command or tick
//  m_axis   | out | m_axis_tvalid & m_axis_tready   | pin levels and events
//  cfg      | in  | cfg_we                          | half_period
//
// One transaction a cycle while the output is not stalled; the item waits in the input
// register and its result is loaded into the output register when the engine steps.
// arst_n releases both pins high, idles the engine, sets half_period to 360.
// A stalled output holds its result; the input register still takes one
// more transaction, then s_axis_tready drops until m_axis_tready returns.
`default_nettype none

module i2c_master_bit_engine_top import i2cm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tgt_addr[6:0], reg_addr[14:7], length[30:15], write_byte[38:31], sda_level[39]
	input  wire logic [39:0] s_axis_tdata,
	// action[1:0], kind[3:2]
	input  wire logic [3:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// scl[0], sda[1], busy_res[2], want_byte[3], read_valid[4], read_data[12:5],
	// done_res[13], status[15:14]
	output logic [15:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	logic        s1_vld_q;
	item_t       item_s1;
	logic        adv;
	result_t     res;
	result_t     out_q;
	logic        out_vld_q;
	logic [15:0] half_period_q;

	assign adv           = s1_vld_q && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !s1_vld_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_period_q <= HALF_PERIOD_RST;
		else if (cfg_we)
			half_period_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_vld_q <= 1'b0;
		else if (s_axis_tready)
			s1_vld_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.action     <= s_axis_tuser[1:0];
			item_s1.kind       <= s_axis_tuser[3:2];
			item_s1.tgt_addr   <= s_axis_tdata[6:0];
			item_s1.reg_addr   <= s_axis_tdata[14:7];
			item_s1.length     <= s_axis_tdata[30:15];
			item_s1.write_byte <= s_axis_tdata[38:31];
			item_s1.sda_level  <= s_axis_tdata[39];
		end
	end

	i2cm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.item        (item_s1),
		.half_period (half_period_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_q.read_last;
	assign m_axis_tdata  = {out_q.status, out_q.done_res, out_q.read_data, out_q.read_valid,
		out_q.want_byte, out_q.busy_res, out_q.sda, out_q.scl};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for i2c_master_bit_engine_top, directed table then random traffic.
// Depends on i2cm_pkg and the RTL under design/; the bus model predicts all but typed rows.
`timescale 1ns / 100ps

module tb import i2cm_pkg::*;;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 480;
	localparam int DIR_ROWS = 13;

	localparam result_t RES_IDLE = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, ST_OK};
	localparam result_t RES_EMPTY = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1, ST_EMPTY};

	typedef struct packed {
		logic        cfg_now;
		logic [15:0] cfg_val;
		item_t       cmd;
		logic [7:0]  reps;
		logic        typed;
		result_t     res;
	} drow_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	result_t pin_state_q [$];
	drow_t   dir_tab [DIR_ROWS];

	// bus model state
	logic [15:0] cfg_half;
	phase_t      bus_ph;
	logic [15:0] ph_left;
	logic [3:0]  bit_n;
	logic [7:0]  shifter;
	logic [15:0] bytes_due;
	logic [7:0]  hold_byte;
	logic        hold_full;
	logic [1:0]  t_kind;
	logic [6:0]  t_dev;
	logic [7:0]  t_reg;
	logic        scl_lvl;
	logic        sda_lvl;
	stage_t      seq_stage;
	logic        slave_nack;
	logic [1:0]  end_code;
	result_t     step_out;

	i2c_master_bit_engine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void bus_reset();
		cfg_half = HALF_PERIOD_RST;
		bus_ph = P_IDLE;
		ph_left = '0;
		bit_n = '0;
		shifter = '0;
		bytes_due = '0;
		hold_byte = '0;
		hold_full = 1'b0;
		t_kind = KIND_WR;
		t_dev = '0;
		t_reg = '0;
		scl_lvl = 1'b1;
		sda_lvl = 1'b1;
		seq_stage = STG_ADDR;
		slave_nack = 1'b0;
		end_code = ST_OK;
	endfunction

	function automatic void begin_phase(input phase_t p);
		bus_ph = p;
		ph_left = (cfg_half != 16'd0) ? cfg_half : 16'd1;
		case (p)
			P_ST_SDAH, P_TX_REL, P_AK_SDAH, P_RX_REL, P_MA_SDAH, P_MN_SDAH, P_SP_SDAH: begin
				sda_lvl = 1'b1;
			end
			P_ST_SDAL, P_MA_SDAL, P_SP_SDAL: begin
				sda_lvl = 1'b0;
			end
			P_TX_BIT: begin
				sda_lvl = shifter[7];
			end
			P_ST_SCLH, P_TX_SCLH, P_AK_SCLH, P_RX_SCLH, P_MA_SCLH, P_MN_SCLH, P_SP_SCLH: begin
				scl_lvl = 1'b1;
			end
			default: begin
				scl_lvl = 1'b0;
			end
		endcase
	endfunction

	function automatic void shift_out(input logic [7:0] v);
		shifter = v;
		bit_n = '0;
		begin_phase(P_TX_BIT);
	endfunction

	function automatic void feed_data();
		if (hold_full) begin
			hold_full = 1'b0;
			if (bytes_due != 16'd0)
				bytes_due--;
			shift_out(hold_byte);
		end else begin
			bus_ph = P_WAIT;
		end
	endfunction

	function automatic void begin_read();
		bit_n = '0;
		shifter = '0;
		begin_phase(P_RX_REL);
	endfunction

	function automatic void handle_ack();
		if (slave_nack) begin
			end_code = ST_NACK;
			begin_phase(P_SP_SDAL);
			return;
		end
		case (seq_stage)
			STG_ADDR: begin
				if (t_kind == KIND_RD) begin
					begin_read();
				end else if (t_kind == KIND_WR) begin
					seq_stage = STG_DATA;
					feed_data();
				end else begin
					seq_stage = STG_REG;
					shift_out(t_reg);
				end
			end
			STG_REG: begin
				if (t_kind == KIND_REGWR) begin
					seq_stage = STG_DATA;
					feed_data();
				end else begin
					seq_stage = STG_RADDR;
					begin_phase(P_ST_SDAH);
				end
			end
			STG_RADDR: begin
				begin_read();
			end
			default: begin
				if (bytes_due != 16'd0) begin
					feed_data();
				end else begin
					end_code = ST_OK;
					begin_phase(P_SP_SDAL);
				end
			end
		endcase
	endfunction

	function automatic void phase_over(input logic sda_in);
		case (bus_ph)
			P_ST_SDAH: begin_phase(P_ST_SCLH);
			P_ST_SCLH: begin_phase(P_ST_SDAL);
			P_ST_SDAL: begin_phase(P_ST_SCLL);
			P_ST_SCLL: begin
				shift_out({t_dev, (seq_stage == STG_RADDR) ||
					(seq_stage == STG_ADDR && t_kind == KIND_RD)});
			end
			P_TX_BIT: begin_phase(P_TX_SCLH);
			P_TX_SCLH: begin_phase(P_TX_SCLL);
			P_TX_SCLL: begin
				shifter = shifter << 1;
				bit_n++;
				if (bit_n < 4'd8)
					begin_phase(P_TX_BIT);
				else
					begin_phase(P_TX_REL);
			end
			P_TX_REL: begin_phase(P_AK_SDAH);
			P_AK_SDAH: begin_phase(P_AK_SCLH);
			P_AK_SCLH: begin
				slave_nack = sda_in;
				begin_phase(P_AK_SCLL);
			end
			P_AK_SCLL: handle_ack();
			P_RX_REL: begin_phase(P_RX_SCLH);
			P_RX_SCLH: begin
				shifter = {shifter[6:0], sda_in};
				bit_n++;
				if (bit_n >= 4'd8) begin
					if (bytes_due != 16'd0)
						bytes_due--;
					step_out.read_valid = 1'b1;
					step_out.read_data = shifter;
					step_out.read_last = (bytes_due == 16'd0);
				end
				begin_phase(P_RX_SCLL);
			end
			P_RX_SCLL: begin
				if (bit_n < 4'd8)
					begin_phase(P_RX_SCLH);
				else if (bytes_due != 16'd0)
					begin_phase(P_MA_SDAL);
				else
					begin_phase(P_MN_SDAH);
			end
			P_MA_SDAL: begin_phase(P_MA_SCLH);
			P_MA_SCLH: begin_phase(P_MA_SCLL);
			P_MA_SCLL: begin_phase(P_MA_SDAH);
			P_MA_SDAH: begin_read();
			P_MN_SDAH: begin_phase(P_MN_SCLH);
			P_MN_SCLH: begin_phase(P_MN_SCLL);
			P_MN_SCLL: begin
				end_code = ST_OK;
				begin_phase(P_SP_SDAL);
			end
			P_SP_SDAL: begin_phase(P_SP_SCLH);
			P_SP_SCLH: begin_phase(P_SP_SDAH);
			default: begin
				bus_ph = P_IDLE;
				ph_left = '0;
				hold_full = 1'b0;
				bytes_due = '0;
				step_out.done_res = 1'b1;
				step_out.status = end_code;
			end
		endcase
	endfunction

	function automatic void tick_bus(input logic sda_in);
		if (bus_ph == P_IDLE)
			return;
		if (bus_ph == P_WAIT) begin
			if (hold_full)
				feed_data();
			return;
		end
		if (ph_left > 16'd1) begin
			ph_left--;
			return;
		end
		phase_over(sda_in);
	endfunction

	function automatic logic byte_wanted();
		return bus_ph != P_IDLE && (t_kind == KIND_WR || t_kind == KIND_REGWR) &&
			bytes_due != 16'd0 && !hold_full;
	endfunction

	function automatic result_t bus_step(input item_t c);
		step_out = '0;
		case (c.action)
			ACT_TICK: tick_bus(c.sda_level);
			ACT_BEGIN: begin
				if (bus_ph == P_IDLE) begin
					if (c.length == 16'd0) begin
						step_out.done_res = 1'b1;
						step_out.status = ST_EMPTY;
					end else begin
						t_kind = c.kind;
						t_dev = c.tgt_addr;
						t_reg = c.reg_addr;
						bytes_due = c.length;
						hold_full = 1'b0;
						seq_stage = STG_ADDR;
						slave_nack = 1'b0;
						end_code = ST_OK;
						bit_n = '0;
						shifter = '0;
						begin_phase(P_ST_SDAH);
					end
				end
			end
			ACT_BYTE: begin
				if (byte_wanted()) begin
					hold_byte = c.write_byte;
					hold_full = 1'b1;
				end
			end
			default: ;
		endcase
		step_out.scl = scl_lvl;
		step_out.sda = sda_lvl;
		step_out.busy_res = (bus_ph != P_IDLE);
		step_out.want_byte = byte_wanted();
		return step_out;
	endfunction

	// Mostly well-formed traffic driven off the model state; a few percent is noise.
	function automatic item_t next_cmd();
		item_t c;
		int r;
		c.action = ACT_TICK;
		c.kind = 2'($urandom_range(3));
		c.tgt_addr = 7'($urandom);
		c.reg_addr = 8'($urandom);
		c.length = 16'($urandom);
		c.write_byte = 8'($urandom);
		c.sda_level = 1'($urandom);
		r = $urandom_range(99);
		if (r < 3) begin
			c.action = ACT_NOP;
		end else if (r < 6) begin
			c.action = ACT_BEGIN;
		end else if (r < 9) begin
			c.action = ACT_BYTE;
		end else if (bus_ph == P_IDLE) begin
			c.action = ACT_BEGIN;
			r = $urandom_range(99);
			if (r < 6)
				c.length = 16'd0;
			else if (r >= 14)
				c.length = 16'($urandom_range(1, 3));
		end else if (byte_wanted() && $urandom_range(99) < 70) begin
			c.action = ACT_BYTE;
		end else if (bus_ph == P_AK_SCLH) begin
			// long requests are cut short by a target NACK
			c.sda_level = (bytes_due > 16'd8) || ($urandom_range(99) < 8);
		end
		return c;
	endfunction

	task automatic send_cmd(input item_t c, input logic typed, input result_t res);
		result_t r;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= {c.kind, c.action};
		s_axis_tdata <= {c.sda_level, c.write_byte, c.length, c.reg_addr, c.tgt_addr};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = bus_step(c);
		pin_state_q.push_back(typed ? res : r);
		@(negedge clk);
	endtask

	task automatic write_half_period(input logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		while (pin_state_q.size() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_half = v;
	endtask

	function automatic void check_field(input string fname, input int unsigned e,
		input int unsigned a);
		if (e != a) begin
			errors++;
			$error("%s: expected %0d, got %0d", fname, e, a);
		end
	endfunction

	always @(negedge clk)
		m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		result_t got;
		result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3],
				m_axis_tdata[4], m_axis_tdata[12:5], m_axis_tlast, m_axis_tdata[13],
				m_axis_tdata[15:14]};
			if (pin_state_q.size() == 0) begin
				errors++;
				$error("unexpected transaction on m_axis: %h", got);
			end else begin
				due = pin_state_q.pop_front();
				check_field("scl", due.scl, got.scl);
				check_field("sda", due.sda, got.sda);
				check_field("busy_res", due.busy_res, got.busy_res);
				check_field("want_byte", due.want_byte, got.want_byte);
				check_field("read_valid", due.read_valid, got.read_valid);
				check_field("read_data", due.read_data, got.read_data);
				check_field("read_last", due.read_last, got.read_last);
				check_field("done_res", due.done_res, got.done_res);
				check_field("status", due.status, got.status);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int k;
		int ph_i;
		int counted;
		item_t c;
		bus_reset();
		// idle bus at the reset rate: ignored commands and zero-length requests
		dir_tab[0] = '{1'b0, 16'd0, '{ACT_TICK, KIND_WR, 7'd0, 8'd0, 16'd0, 8'd0, 1'b0},
			8'd1, 1'b1, RES_IDLE};
		dir_tab[1] = '{1'b0, 16'd0, '{ACT_TICK, KIND_REGRD, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1},
			8'd1, 1'b1, RES_IDLE};
		dir_tab[2] = '{1'b0, 16'd0, '{ACT_NOP, KIND_REGRD, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1},
			8'd1, 1'b1, RES_IDLE};
		dir_tab[3] = '{1'b0, 16'd0, '{ACT_BYTE, KIND_RD, 7'h2A, 8'h55, 16'h1234, 8'hA5, 1'b0},
			8'd1, 1'b1, RES_IDLE};
		dir_tab[4] = '{1'b0, 16'd0, '{ACT_BEGIN, KIND_REGRD, 7'h7F, 8'hFF, 16'd0, 8'hFF, 1'b1},
			8'd1, 1'b1, RES_EMPTY};
		dir_tab[5] = '{1'b0, 16'd0, '{ACT_BEGIN, KIND_WR, 7'd0, 8'd0, 16'd0, 8'd0, 1'b0},
			8'd1, 1'b1, RES_EMPTY};
		// half period zero behaves as one
		dir_tab[6] = '{1'b1, 16'd0, '{ACT_BEGIN, KIND_WR, 7'h55, 8'hAA, 16'd2, 8'd0, 1'b0},
			8'd1, 1'b0, '0};
		dir_tab[7] = '{1'b0, 16'd0, '{ACT_BEGIN, KIND_RD, 7'd0, 8'd0, 16'hFFFF, 8'd0, 1'b0},
			8'd1, 1'b0, '0};
		dir_tab[8] = '{1'b0, 16'd0, '{ACT_BYTE, KIND_WR, 7'd0, 8'd0, 16'd0, 8'hFF, 1'b0},
			8'd1, 1'b0, '0};
		dir_tab[9] = '{1'b0, 16'd0, '{ACT_BYTE, KIND_WR, 7'd0, 8'd0, 16'd0, 8'h00, 1'b0},
			8'd1, 1'b0, '0};
		dir_tab[10] = '{1'b0, 16'd0, '{ACT_NOP, KIND_WR, 7'd0, 8'd0, 16'd0, 8'd0, 1'b0},
			8'd1, 1'b0, '0};
		dir_tab[11] = '{1'b0, 16'd0, '{ACT_TICK, KIND_WR, 7'd0, 8'd0, 16'd0, 8'd0, 1'b0},
			8'd12, 1'b0, '0};
		dir_tab[12] = '{1'b0, 16'd0, '{ACT_TICK, KIND_WR, 7'd0, 8'd0, 16'd0, 8'd0, 1'b1},
			8'd4, 1'b0, '0};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].cfg_now)
				write_half_period(dir_tab[i].cfg_val);
			for (k = 0; k < dir_tab[i].reps; k++)
				send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
		end

		for (ph_i = 0; ph_i < 4; ph_i++) begin
			case (ph_i)
				1: begin
					write_half_period(16'd1);
					src_idle_pct = 64;
				end
				2: begin
					write_half_period(16'd2);
					src_idle_pct = 0;
					sink_stall_pct = 64;
				end
				3: begin
					write_half_period(16'($urandom_range(1, 3)));
					src_idle_pct = 14;
					sink_stall_pct = 14;
				end
				default: ;
			endcase
			counted = 0;
			while (counted < ITEMS_PER_PHASE || bus_ph != P_IDLE) begin
				c = next_cmd();
				if ((c.action == ACT_TICK && bus_ph != P_IDLE) ||
					(c.action == ACT_BEGIN && bus_ph == P_IDLE) ||
					(c.action == ACT_BYTE && byte_wanted()))
					counted++;
				send_cmd(c, 1'b0, '0);
			end
		end

		// slowest rate: the bus only gets as far as the first phase
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_half_period(16'hFFFF);
		for (i = 0; i < 40; i++)
			send_cmd(next_cmd(), 1'b0, '0);

		s_axis_tvalid <= 1'b0;
		while (pin_state_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pin_state_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
